// ===== rtl/scancode_and_mouse_packet_decoder_macros.svh =====
// Assertion macros shared by the scancode and mouse packet decoder.
`ifndef SCANCODE_AND_MOUSE_PACKET_DECODER_MACROS_SVH
`define SCANCODE_AND_MOUSE_PACKET_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMPD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMPD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/smpd_pkg.sv =====
// Constants, types and key tables of the scancode and mouse packet decoder.
package smpd_pkg;

   localparam logic [7:0]  HEADER_BYTE = 8'hF8;
   localparam logic [6:0]  KEY_LSHIFT  = 7'h2A;
   localparam logic [6:0]  KEY_RSHIFT  = 7'h36;
   localparam logic [6:0]  KEY_CAPS    = 7'h3A;
   localparam logic [6:0]  LAST_CODE   = 7'h3A;
   localparam logic [12:0] POS_LIMIT   = 13'd4096;

   localparam int          LIMIT_W      = 13;
   localparam int          POS_W        = 12;
   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd400;

   // Register index, taken from bit 2 of the byte address.
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic shift;
      logic caps;
   } key_flags_type;

   typedef struct packed {
      logic          valid;
      logic [7:0]    char_code;
      key_flags_type flags;
   } key_event_type;

   // Unshifted table; entries past the last code are padding and never emitted.
   localparam logic [7:0] MAP_PLAIN [0:63] = '{
      8'h80, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h80,
      8'h84, 8'h20, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] MAP_SHIFT [0:63] = '{
      8'h80, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h60, 8'h82, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h80,
      8'h84, 8'h20, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

endpackage

// ===== rtl/smpd_key_decode.sv =====
// Key event decode: modifier flag update and character table lookup.
module smpd_key_decode
   import smpd_pkg::*;
(
   input  logic [7:0]    scan_byte,
   input  key_flags_type flags_cur,
   output key_event_type key_event
);

   logic [6:0]    code;
   logic          is_shift_key;
   logic [7:0]    plain_char;
   logic [7:0]    shift_char;
   logic          is_letter;
   key_flags_type flags_new;

   assign code         = scan_byte[6:0];
   assign is_shift_key = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
   assign plain_char   = MAP_PLAIN[code[5:0]];
   assign shift_char   = MAP_SHIFT[code[5:0]];
   assign is_letter    = (plain_char >= 8'h61) && (plain_char <= 8'h7A);

   always_comb begin
      flags_new           = flags_cur;
      key_event.valid     = 1'b0;
      key_event.char_code = 8'h00;
      if (scan_byte[7]) begin
         if (is_shift_key) begin
            flags_new.shift = 1'b0;
         end
      end else if (code <= LAST_CODE) begin
         if (is_shift_key) begin
            flags_new.shift = 1'b1;
         end else if (code == KEY_CAPS) begin
            flags_new.caps = ~flags_cur.caps;
         end
         key_event.valid = 1'b1;
         // Caps alone raises letters only; shift alone uses the full shifted table.
         if (flags_new.caps && !flags_new.shift) begin
            key_event.char_code = is_letter ? shift_char : plain_char;
         end else if (flags_new.shift && !flags_new.caps) begin
            key_event.char_code = shift_char;
         end else begin
            key_event.char_code = plain_char;
         end
      end
      key_event.flags = flags_new;
   end

endmodule

// ===== rtl/smpd_axis_move.sv =====
// One cursor axis: applies a signed move if the result lies strictly between zero and the screen limit.
module smpd_axis_move
   import smpd_pkg::*;
(
   input  logic [POS_W-1:0]   pos_cur,
   input  logic [7:0]         delta,
   input  logic [LIMIT_W-1:0] limit,
   output logic [POS_W-1:0]   pos_new
);

   logic signed [POS_W+1:0] sum;
   logic [LIMIT_W-1:0]      lim_clamped;

   assign lim_clamped = (limit > POS_LIMIT) ? POS_LIMIT : limit;
   assign sum = $signed({2'b00, pos_cur}) + (POS_W+2)'($signed(delta));

   always_comb begin
      if ((sum > 0) && (sum < $signed({1'b0, lim_clamped}))) begin
         pos_new = sum[POS_W-1:0];
      end else begin
         pos_new = pos_cur;
      end
   end

endmodule

// ===== rtl/scancode_and_mouse_packet_decoder.sv =====
// Scancode and mouse packet decoder, top level.
//
// Request channel: one keyboard controller byte per request (req_valid,
// req_stall, req_scan_byte). Result channel: one result per request with the
// key character, cursor position and modifier flags (rsp_valid, rsp_stall).
// A byte 0xF8 while idle opens a mouse packet; the next two non-header bytes move x and y.
// Other idle bytes are key events.
// The result of an accepted request is registered and shows in the cycle after
// it is taken. Throughput is one request per cycle unless the receiver stalls;
// decode, table lookup and cursor add all sit before the result register.
// When the receiver stalls, the result register holds and req_stall rises only
// while that register is full and stalled, so a request is taken in the same
// cycle the previous result leaves.
// Synchronous reset clears the packet stage, modifier flags, cursor and result
// valid, and sets the screen limits to 640 by 400. The limit registers are
// written at csr_ addresses 0 and 4; user writes only while idle, not enforced.
`include "scancode_and_mouse_packet_decoder_macros.svh"
module scancode_and_mouse_packet_decoder
   import smpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_scan_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_key_valid,
   output logic [7:0]         rsp_key_char,
   output logic [POS_W-1:0]   rsp_cursor_x,
   output logic [POS_W-1:0]   rsp_cursor_y,
   output logic               rsp_shift_active,
   output logic               rsp_caps_active,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DX,
      ST_DY
   } stage_type;

   stage_type          stage_ff, stage_in;
   key_flags_type      flags_ff, flags_in;
   logic [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [LIMIT_W-1:0] width_ff, height_ff;
   logic               rsp_valid_ff;
   logic               rsp_key_valid_ff, rsp_key_valid_in;
   logic [7:0]         rsp_key_char_ff, rsp_key_char_in;

   logic               req_take;
   logic               csr_write;
   logic               is_header;
   key_event_type      key_event;
   logic [POS_W-1:0]   pos_x_moved, pos_y_moved;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_take   = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign is_header  = (req_scan_byte == HEADER_BYTE);

   smpd_key_decode u_key (
      .scan_byte (req_scan_byte),
      .flags_cur (flags_ff),
      .key_event (key_event)
   );

   smpd_axis_move u_move_x (
      .pos_cur (pos_x_ff),
      .delta   (req_scan_byte),
      .limit   (width_ff),
      .pos_new (pos_x_moved)
   );

   smpd_axis_move u_move_y (
      .pos_cur (pos_y_ff),
      .delta   (req_scan_byte),
      .limit   (height_ff),
      .pos_new (pos_y_moved)
   );

   always_comb begin
      stage_in         = stage_ff;
      flags_in         = flags_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      rsp_key_valid_in = 1'b0;
      rsp_key_char_in  = 8'h00;
      unique case (stage_ff)
         ST_DX: begin
            if (!is_header) begin
               pos_x_in = pos_x_moved;
               stage_in = ST_DY;
            end
         end
         ST_DY: begin
            if (!is_header) begin
               pos_y_in = pos_y_moved;
               stage_in = ST_IDLE;
            end
         end
         default: begin
            if (is_header) begin
               stage_in = ST_DX;
            end else begin
               stage_in         = ST_IDLE;
               flags_in         = key_event.flags;
               rsp_key_valid_in = key_event.valid;
               rsp_key_char_in  = key_event.char_code;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff         <= ST_IDLE;
         flags_ff         <= '0;
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         width_ff         <= WIDTH_RESET;
         height_ff        <= HEIGHT_RESET;
         rsp_valid_ff     <= 1'b0;
         rsp_key_valid_ff <= 1'b0;
         rsp_key_char_ff  <= 8'h00;
      end else begin
         if (csr_write) begin
            if (csr_paddr[2] == REG_SCREEN_WIDTH) begin
               width_ff <= csr_pwdata[LIMIT_W-1:0];
            end else begin
               height_ff <= csr_pwdata[LIMIT_W-1:0];
            end
         end
         if (req_take) begin
            stage_ff         <= stage_in;
            flags_ff         <= flags_in;
            pos_x_ff         <= pos_x_in;
            pos_y_ff         <= pos_y_in;
            rsp_valid_ff     <= 1'b1;
            rsp_key_valid_ff <= rsp_key_valid_in;
            rsp_key_char_ff  <= rsp_key_char_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_SCREEN_HEIGHT) begin
         csr_prdata = {{(32-LIMIT_W){1'b0}}, height_ff};
      end else begin
         csr_prdata = {{(32-LIMIT_W){1'b0}}, width_ff};
      end
   end

   // The flag and cursor registers only change with a request, so they double
   // as the result payload.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_valid    = rsp_key_valid_ff;
   assign rsp_key_char     = rsp_key_char_ff;
   assign rsp_cursor_x     = pos_x_ff;
   assign rsp_cursor_y     = pos_y_ff;
   assign rsp_shift_active = flags_ff.shift;
   assign rsp_caps_active  = flags_ff.caps;

   `SMPD_ASSERT_NOW(a_char_zero_without_key, clock, reset, rsp_valid_ff && !rsp_key_valid_ff, rsp_key_char_ff == 8'h00, "key_char nonzero without key_valid")
   `SMPD_ASSERT_NEXT(a_header_opens_packet, clock, reset, req_take && stage_ff == ST_IDLE && is_header, stage_ff == ST_DX && !rsp_key_valid_ff, "idle header did not open a packet")
   `SMPD_ASSERT_NEXT(a_packet_byte_no_key, clock, reset, req_take && stage_ff != ST_IDLE, !rsp_key_valid_ff && $stable(flags_ff), "packet byte treated as a key")
   `SMPD_ASSERT_NEXT(a_dx_keeps_y, clock, reset, req_take && stage_ff == ST_DX, pos_y_ff == $past(pos_y_ff), "dx byte changed cursor y")

endmodule
